@@ hw/rtl/scs_pkg.sv @@
package scs_pkg;

  localparam int NUM_MOTORS = 5;
  localparam int MOTOR_W    = 3;
  localparam int COILS      = 4;
  localparam int DRIVE_W    = NUM_MOTORS * COILS;

  localparam int STEPS_W = 16;
  localparam int TIMER_W = 20;
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 20;

  localparam logic [STEPS_W-1:0] FORWARD_STEPS_RST = 16'd573;
  localparam logic [STEPS_W-1:0] BACK_STEPS_RST    = 16'd409;
  localparam logic [STEPS_W-1:0] STEP_PERIOD_RST   = 16'd1953;
  localparam logic [TIMER_W-1:0] PAUSE_TICKS_RST   = 20'd20000;

  // Full-step phase sequence, first entry is the start of every move
  localparam logic [3:0] PHASE_TAB [4] = '{4'b1100, 4'b0110, 4'b0011, 4'b1001};

  // Command letters in motor order: r, l, f, b, d
  localparam logic [CHAR_W-1:0] LETTER_TAB [5] = '{8'h72, 8'h6C, 8'h66, 8'h62, 8'h64};

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FWD   = 2'd1,
    ST_PAUSE = 2'd2,
    ST_BACK  = 2'd3
  } seq_stage_t;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ACK_NONE = 2'd0,
    ACK_GOOD = 2'd1,
    ACK_BAD  = 2'd2,
    ACK_BUSY = 2'd3
  } ack_t;

  typedef enum logic [1:0] {
    REG_FORWARD_STEPS = 2'd0,
    REG_BACK_STEPS    = 2'd1,
    REG_STEP_PERIOD   = 2'd2,
    REG_PAUSE_TICKS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t               operation;
    logic [CHAR_W-1:0] char_code;
  } cmd_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] coil_drive;
    ack_t               ack;
    logic               busy_res;
  } res_item_t;

  // Coil j takes pattern bit 3-j, or bit j when the move runs reversed
  function automatic logic [3:0] coil_word(input logic [1:0] phase, input logic rev);
    logic [3:0] pat;
    logic [3:0] w;
    pat = PHASE_TAB[phase];
    for (int j = 0; j < COILS; j++) begin
      w[j] = rev ? pat[j] : pat[COILS-1-j];
    end
    return w;
  endfunction

endpackage

@@ hw/rtl/stepper_command_sequencer.sv @@
// Command sequencer for up to five four-coil unipolar steppers in full-step mode. Each input
// item is either a command byte or one timer tick. A letter r, l, f, b or d selects a motor
// (upper case reverses direction) and starts a sequence: forward_steps steps in that direction,
// each phase pattern held for step_period ticks (0 behaves as 1), then pause_ticks ticks with the
// coils off, then back_steps steps the other way, then coils off and idle. Zero-length stages are
// skipped within the same item. A command that arrives while a sequence runs is answered with
// the busy code and changes nothing; an unknown byte is answered with the bad-letter code. Every
// item yields exactly one result item carrying the coil word, the command answer and the busy
// flag after that item. Timing: one item is taken per cycle while cmd_stall is low; its result is
// registered in the result register, or in the skid register if that one is stalled; the whole
// update is one pass of logic from the state registers to the output stage. A two-entry output
// stage (result register plus skid register) lets the block take one more item after res_stall
// goes high; cmd_stall rises only when both entries hold results. Configuration writes are taken
// every cycle (cfg_ready is always high) and must be made while no sequence runs.
module stepper_command_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  scs_pkg::cmd_item_t        cmd_item,
  output logic                      res_valid,
  input  logic                      res_stall,
  output scs_pkg::res_item_t        res_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  scs_pkg::cfg_reg_t         cfg_index,
  input  logic [scs_pkg::CFG_W-1:0] cfg_data
);
  import scs_pkg::*;

  // Configuration registers
  logic [STEPS_W-1:0] forward_steps;
  logic [STEPS_W-1:0] back_steps;
  logic [STEPS_W-1:0] step_period;
  logic [TIMER_W-1:0] pause_ticks;

  // Sequencer state
  seq_stage_t         seq_stage, seq_stage_next;
  logic [MOTOR_W-1:0] motor_sel, motor_sel_next;
  logic               move_reverse, move_reverse_next;
  logic [STEPS_W-1:0] step_count, step_count_next;
  logic [TIMER_W-1:0] wait_timer, wait_timer_next;
  logic [3:0]         coil_pattern, coil_pattern_next;
  ack_t               ack_next;

  // Output stage: result register plus skid entry
  logic      skid_valid;
  res_item_t skid_item;
  res_item_t res_next;

  logic cmd_acc;
  logic res_taken;

  // Next-state helpers
  logic               enter;
  seq_stage_t         enter_stage;
  seq_stage_t         land_stage;
  logic [TIMER_W-1:0] period_ticks;
  logic [TIMER_W-1:0] tick_left;
  logic [STEPS_W-1:0] step_inc;
  logic [STEPS_W-1:0] step_limit;
  logic               is_upper;
  logic [CHAR_W-1:0]  lc_char;
  logic               matched;
  logic [MOTOR_W-1:0] match_sel;

  assign cfg_ready = 1'b1;
  assign cmd_stall = skid_valid;
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign res_taken = res_valid && !res_stall;

  // A zero step period still holds each pattern for one tick
  assign period_ticks = (step_period == '0) ? TIMER_W'(1) : TIMER_W'(step_period);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_steps <= FORWARD_STEPS_RST;
      back_steps    <= BACK_STEPS_RST;
      step_period   <= STEP_PERIOD_RST;
      pause_ticks   <= PAUSE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORWARD_STEPS: forward_steps <= cfg_data[STEPS_W-1:0];
        REG_BACK_STEPS:    back_steps    <= cfg_data[STEPS_W-1:0];
        REG_STEP_PERIOD:   step_period   <= cfg_data[STEPS_W-1:0];
        REG_PAUSE_TICKS:   pause_ticks   <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state for one item
  always_comb begin
    seq_stage_next    = seq_stage;
    motor_sel_next    = motor_sel;
    move_reverse_next = move_reverse;
    step_count_next   = step_count;
    wait_timer_next   = wait_timer;
    coil_pattern_next = coil_pattern;
    ack_next          = ACK_NONE;
    enter             = 1'b0;
    enter_stage       = ST_IDLE;
    land_stage        = ST_IDLE;

    tick_left  = (wait_timer != '0) ? wait_timer - TIMER_W'(1) : '0;
    step_inc   = step_count + STEPS_W'(1);
    step_limit = (seq_stage == ST_FWD) ? forward_steps : back_steps;

    // Fold upper case onto lower case and look the letter up
    is_upper  = (cmd_item.char_code >= CHAR_UPPER_A) && (cmd_item.char_code <= CHAR_UPPER_Z);
    lc_char   = is_upper ? (cmd_item.char_code | CHAR_CASE_BIT) : cmd_item.char_code;
    matched   = 1'b0;
    match_sel = '0;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (!matched && lc_char == LETTER_TAB[m]) begin
        matched   = 1'b1;
        match_sel = MOTOR_W'(m);
      end
    end

    if (cmd_item.operation == OP_TICK) begin
      if (seq_stage != ST_IDLE) begin
        wait_timer_next = tick_left;
        if (tick_left == '0) begin
          if (seq_stage == ST_PAUSE) begin
            enter       = 1'b1;
            enter_stage = ST_BACK;
          end else if (step_inc == '0 || step_inc >= step_limit) begin
            // Move done: forward goes on to the pause, return ends the sequence
            enter       = 1'b1;
            enter_stage = (seq_stage == ST_FWD) ? ST_PAUSE : ST_IDLE;
          end else begin
            step_count_next   = step_inc;
            wait_timer_next   = period_ticks;
            coil_pattern_next = coil_word(step_inc[1:0],
                                          (seq_stage == ST_BACK) ? !move_reverse : move_reverse);
          end
        end
      end
    end else begin
      if (seq_stage != ST_IDLE) begin
        ack_next = ACK_BUSY;
      end else if (matched) begin
        ack_next          = ACK_GOOD;
        motor_sel_next    = match_sel;
        move_reverse_next = is_upper;
        enter             = 1'b1;
        enter_stage       = ST_FWD;
      end else begin
        ack_next = ACK_BAD;
      end
    end

    // Stage entry: skip stages of zero length in order
    if (enter) begin
      land_stage = enter_stage;
      if (land_stage == ST_FWD && forward_steps == '0) begin
        land_stage = ST_PAUSE;
      end
      if (land_stage == ST_PAUSE && pause_ticks == '0) begin
        land_stage = ST_BACK;
      end
      if (land_stage == ST_BACK && back_steps == '0) begin
        land_stage = ST_IDLE;
      end
      seq_stage_next    = land_stage;
      step_count_next   = '0;
      wait_timer_next   = '0;
      coil_pattern_next = '0;
      case (land_stage)
        ST_FWD: begin
          wait_timer_next   = period_ticks;
          coil_pattern_next = coil_word(2'd0, move_reverse_next);
        end
        ST_BACK: begin
          wait_timer_next   = period_ticks;
          coil_pattern_next = coil_word(2'd0, !move_reverse_next);
        end
        ST_PAUSE: begin
          wait_timer_next = pause_ticks;
        end
        default: ;
      endcase
    end
  end

  // Result item from the state after this item
  always_comb begin
    res_next.coil_drive = '0;
    if (seq_stage_next == ST_FWD || seq_stage_next == ST_BACK) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        if (motor_sel_next == MOTOR_W'(m)) begin
          res_next.coil_drive[COILS*m +: COILS] = coil_pattern_next;
        end
      end
    end
    res_next.ack      = ack_next;
    res_next.busy_res = (seq_stage_next != ST_IDLE);
  end

  // Sequencer state: advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_stage    <= ST_IDLE;
      motor_sel    <= '0;
      move_reverse <= 1'b0;
      step_count   <= '0;
      wait_timer   <= '0;
      coil_pattern <= '0;
    end else if (cmd_acc) begin
      seq_stage    <= seq_stage_next;
      motor_sel    <= motor_sel_next;
      move_reverse <= move_reverse_next;
      step_count   <= step_count_next;
      wait_timer   <= wait_timer_next;
      coil_pattern <= coil_pattern_next;
    end
  end

  // Output stage control: refill from skid first, park a new result in skid when stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (res_taken) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          res_valid <= cmd_acc;
        end
      end else if (!res_valid) begin
        res_valid <= cmd_acc;
      end else if (cmd_acc) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      if (skid_valid) begin
        res_item <= skid_item;
      end else if (cmd_acc) begin
        res_item <= res_next;
      end
    end else if (!res_valid) begin
      if (cmd_acc) begin
        res_item <= res_next;
      end
    end else if (cmd_acc) begin
      skid_item <= res_next;
    end
  end

  // The skid entry is only used behind a full result register
  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry holds a result while the result register is empty");

  // Coils are off whenever no move runs
  a_coils_off: assert property (@(posedge clk) disable iff (rst)
    (seq_stage == ST_IDLE || seq_stage == ST_PAUSE) |-> (coil_pattern == '0))
    else $error("coil pattern set outside a move");

  // A running stage always has ticks left to count
  a_timer_live: assert property (@(posedge clk) disable iff (rst)
    (seq_stage != ST_IDLE) |-> (wait_timer != '0))
    else $error("running stage with an expired timer");

  // A command taken while busy leaves the sequence untouched
  a_busy_cmd_ignored: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && cmd_item.operation == OP_CMD && seq_stage != ST_IDLE) |=>
      (seq_stage == $past(seq_stage) && motor_sel == $past(motor_sel) &&
       wait_timer == $past(wait_timer) && step_count == $past(step_count)))
    else $error("command taken while busy changed the sequence");

endmodule

@@ test/scs_result_checker.sv @@
`timescale 1ns / 1ps

// Watches the command, result and configuration channels of the stepper
// sequencer, predicts every result item and compares it with what comes out.
module scs_result_checker
  import scs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_stall,
  input  cmd_item_t           cmd_item,
  input  logic                res_valid,
  input  logic                res_stall,
  input  res_item_t           res_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  cfg_reg_t            cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output int                  errors,
  output int                  pending,
  output logic                seq_busy
);

  // Two copies of the full-step sequence; shifting right by the phase gives the pattern
  localparam logic [7:0] PHASE_RING = 8'b1100_1100;

  logic [STEPS_W-1:0] cfg_fwd;
  logic [STEPS_W-1:0] cfg_back;
  logic [STEPS_W-1:0] cfg_period;
  logic [TIMER_W-1:0] cfg_pause;

  seq_stage_t         stage;
  logic [MOTOR_W-1:0] motor;
  logic               rev_move;
  logic [STEPS_W-1:0] step_idx;
  logic [TIMER_W-1:0] ticks_left;
  logic [3:0]         coils;

  res_item_t          due_results[$];
  int                 fail_count;

  function automatic logic [3:0] phase_coils(input logic [1:0] phase, input logic rv);
    logic [7:0] ring;
    logic [3:0] pat;
    ring = PHASE_RING >> phase;
    pat  = ring[3:0];
    return rv ? pat : {pat[0], pat[1], pat[2], pat[3]};
  endfunction

  // The return move runs against the direction of the command
  function automatic logic leg_reverse();
    return (stage == ST_BACK) ? !rev_move : rev_move;
  endfunction

  function automatic logic [TIMER_W-1:0] hold_ticks();
    return (cfg_period == '0) ? TIMER_W'(1) : TIMER_W'(cfg_period);
  endfunction

  // Enter a stage, falling through any stage of zero length
  function automatic void begin_stage(input seq_stage_t st);
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      stage      = st;
      step_idx   = '0;
      coils      = '0;
      ticks_left = '0;
      settled    = 1'b1;
      case (st)
        ST_PAUSE: begin
          if (cfg_pause != '0) begin
            ticks_left = cfg_pause;
          end else begin
            st      = ST_BACK;
            settled = 1'b0;
          end
        end
        ST_FWD, ST_BACK: begin
          if (((st == ST_FWD) ? cfg_fwd : cfg_back) != '0) begin
            ticks_left = hold_ticks();
            coils      = phase_coils(2'd0, leg_reverse());
          end else begin
            st      = (st == ST_FWD) ? ST_PAUSE : ST_IDLE;
            settled = 1'b0;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void advance_tick();
    logic [STEPS_W-1:0] limit;
    if (stage == ST_IDLE) return;
    if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
    if (ticks_left != '0) return;
    if (stage == ST_PAUSE) begin
      begin_stage(ST_BACK);
      return;
    end
    limit    = (stage == ST_FWD) ? cfg_fwd : cfg_back;
    step_idx = step_idx + 1'b1;
    if (step_idx == '0 || step_idx >= limit) begin
      begin_stage((stage == ST_FWD) ? ST_PAUSE : ST_IDLE);
      return;
    end
    coils      = phase_coils(step_idx[1:0], leg_reverse());
    ticks_left = hold_ticks();
  endfunction

  function automatic ack_t take_command(input logic [CHAR_W-1:0] ch);
    logic up;
    if (stage != ST_IDLE) return ACK_BUSY;
    up = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z);
    if (up) ch = ch | CHAR_CASE_BIT;
    for (int i = 0; i < NUM_MOTORS && i < 5; i++) begin
      if (ch == LETTER_TAB[i]) begin
        motor    = MOTOR_W'(i);
        rev_move = up;
        begin_stage(ST_FWD);
        return ACK_GOOD;
      end
    end
    return ACK_BAD;
  endfunction

  function automatic res_item_t predict_response(input cmd_item_t item);
    res_item_t r;
    ack_t      a;
    a = ACK_NONE;
    if (item.operation == OP_TICK) advance_tick();
    else a = take_command(item.char_code);
    r.coil_drive = '0;
    if (stage == ST_FWD || stage == ST_BACK)
      r.coil_drive = DRIVE_W'(coils) << (COILS * motor);
    r.ack      = a;
    r.busy_res = (stage != ST_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      cfg_fwd    = FORWARD_STEPS_RST;
      cfg_back   = BACK_STEPS_RST;
      cfg_period = STEP_PERIOD_RST;
      cfg_pause  = PAUSE_TICKS_RST;
      stage      = ST_IDLE;
      motor      = '0;
      rev_move   = 1'b0;
      step_idx   = '0;
      ticks_left = '0;
      coils      = '0;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FORWARD_STEPS: cfg_fwd    = cfg_data[STEPS_W-1:0];
          REG_BACK_STEPS:    cfg_back   = cfg_data[STEPS_W-1:0];
          REG_STEP_PERIOD:   cfg_period = cfg_data[STEPS_W-1:0];
          REG_PAUSE_TICKS:   cfg_pause  = cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) due_results.push_back(predict_response(cmd_item));
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result item coil_drive %h ack %0d busy %0d", $time,
                   res_item.coil_drive, res_item.ack, res_item.busy_res);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (res_item.coil_drive !== want.coil_drive) begin
            $display("%0t: coil_drive expected %h, got %h", $time,
                     want.coil_drive, res_item.coil_drive);
            fail_count++;
          end
          if (res_item.ack !== want.ack) begin
            $display("%0t: ack expected %0d, got %0d", $time, want.ack, res_item.ack);
            fail_count++;
          end
          if (res_item.busy_res !== want.busy_res) begin
            $display("%0t: busy_res expected %0d, got %0d", $time,
                     want.busy_res, res_item.busy_res);
            fail_count++;
          end
        end
      end
    end
    errors   <= fail_count + due_results.size() * 0;
    pending  <= due_results.size();
    seq_busy <= (stage != ST_IDLE);
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Top of the sequencer bench: drives command items, ticks and register writes,
// stalls the result side at random and gives the verdict from the checker.
module testbench;
  import scs_pkg::*;

  // Set on every bad byte used where no move may start: no letter has it
  localparam logic [CHAR_W-1:0] HIGH_BIT = 8'h80;

  typedef struct {
    logic [CFG_W-1:0] fwd;
    logic [CFG_W-1:0] back;
    logic [CFG_W-1:0] period;
    logic [CFG_W-1:0] pause;
    int               items;
    bit               quiet;   // no gaps and no stalls
    bit               safe;    // never start a move
  } phase_plan_t;

  logic             clk;
  logic             rst;
  logic             cmd_valid;
  logic             cmd_stall;
  cmd_item_t        cmd_item;
  logic             res_valid;
  logic             res_stall;
  res_item_t        res_item;
  logic             cfg_valid;
  logic             cfg_ready;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int               errors;
  int               pending;
  logic             seq_busy;

  bit               hurry;
  bit               cmd_held;
  phase_plan_t      plan[$];

  stepper_command_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scs_result_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .seq_busy  (seq_busy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Mostly back-to-back, often a short gap, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (hurry || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: alternate stretches of taking items with stretches of stall
  initial begin
    int n;
    res_stall <= 1'b0;
    forever begin
      n = idle_len();
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      repeat (1 + (hurry ? 0 : $urandom_range(0, 12))) @(posedge clk);
    end
  end

  // Present one item, hold it until taken, then maybe drop valid for a while
  task automatic send_item(input op_t op, input logic [CHAR_W-1:0] ch);
    int gap;
    cmd_item  <= '{operation: op, char_code: ch};
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    gap = idle_len();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      cmd_held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      cmd_held = 1'b1;
    end
  endtask

  task automatic send_tick();
    send_item(OP_TICK, CHAR_W'($urandom_range(0, 255)));
  endtask

  // A motor letter in random case
  task automatic send_letter();
    logic [CHAR_W-1:0] ch;
    ch = LETTER_TAB[$urandom_range(0, NUM_MOTORS - 1)];
    if ($urandom_range(0, 1)) ch = ch & ~CHAR_CASE_BIT;
    send_item(OP_CMD, ch);
  endtask

  // Mostly ticks so that moves run to completion; letters and noise bytes mixed in
  task automatic send_random(input bit safe);
    int                r;
    logic [CHAR_W-1:0] ch;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      send_tick();
    end else if (r < 90 && !safe) begin
      send_letter();
    end else begin
      ch = CHAR_W'($urandom_range(0, 255));
      if (safe) ch = ch | HIGH_BIT;
      send_item(OP_CMD, ch);
    end
  endtask

  // Tick until the sequence is idle; at most one extra idle tick goes out
  task automatic run_out();
    do send_tick(); while (seq_busy);
  endtask

  // Drop valid and wait for every result item still due
  task automatic settle();
    if (cmd_held) begin
      cmd_valid <= 1'b0;
      cmd_held = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold valid across all four writes, drop it after the last
  task automatic write_config(input phase_plan_t p);
    cfg_valid <= 1'b1;
    put_reg(REG_FORWARD_STEPS, p.fwd);
    put_reg(REG_BACK_STEPS, p.back);
    put_reg(REG_STEP_PERIOD, p.period);
    put_reg(REG_PAUSE_TICKS, p.pause);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CHAR_W-1:0] bad_bytes[8];
    phase_plan_t       p;

    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd_item  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FORWARD_STEPS;
    cfg_data  <= '0;
    hurry     = 1'b0;
    cmd_held  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Bytes around the letter ranges, a letter with the high bit set, all-zero and all-one
    bad_bytes = '{8'h00, 8'hFF, 8'h40, 8'h5A, 8'h5B, 8'h60, 8'h7B, 8'hF2};
    foreach (bad_bytes[i]) send_item(OP_CMD, bad_bytes[i]);
    send_item(OP_TICK, 8'h00);   // tick while idle changes nothing
    settle();

    // Short move with a command arriving mid-sequence
    write_config('{fwd: 3, back: 2, period: 2, pause: 3, items: 0, quiet: 0, safe: 0});
    send_item(OP_CMD, LETTER_TAB[3]);
    send_tick();
    send_item(OP_CMD, LETTER_TAB[1] & ~CHAR_CASE_BIT);
    run_out();
    settle();

    // Zero-length stages, a zero period, then random small settings
    plan.push_back('{1, 0, 0, 0, 40, 0, 0});
    plan.push_back('{0, 5, 1, 0, 40, 1, 0});
    plan.push_back('{0, 0, 3, 7, 30, 0, 0});
    plan.push_back('{0, 0, 1, 0, 25, 1, 0});
    repeat (4) begin
      p.fwd    = {4'($urandom_range(0, 15)), 16'($urandom_range(1, 8))};
      p.back   = {4'($urandom_range(0, 15)), 16'($urandom_range(0, 8))};
      p.period = {4'($urandom_range(0, 15)), 16'($urandom_range(0, 4))};
      p.pause  = CFG_W'($urandom_range(0, 6));
      p.items  = 45;
      p.quiet  = 1'b0;
      p.safe   = 1'b0;
      plan.push_back(p);
    end
    // Extremes are loaded but never started: longest forward move, longest
    // return move, longest step hold, longest pause
    plan.push_back('{20'h0FFFF, 3, 20'hF0000, 1, 3, 1, 1});
    plan.push_back('{1, 20'h3FFFF, 1, 0, 3, 1, 1});
    plan.push_back('{1, 1, 20'h0FFFF, 2, 3, 1, 1});
    plan.push_back('{2, 1, 1, 20'hFFFFF, 20, 0, 1});
    plan.push_back('{4, 3, 1, 2, 40, 0, 0});

    foreach (plan[k]) begin
      write_config(plan[k]);
      hurry = plan[k].quiet;
      for (int i = 0; i < plan[k].items; i++) begin
        if (i == 0 && !plan[k].safe) send_letter();
        else send_random(plan[k].safe);
      end
      run_out();
      settle();
      hurry = 1'b0;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
